### sv/modular_exponentiation_defines.svh
// assertion macros for the modular exponentiation block
// expects clk and arst_n in the scope where a macro is used
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// property checked at every edge outside reset
`define MEXP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// consequent checked in the cycle after the antecedent
`define MEXP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/mexp_pkg.sv
// types, constants and the modular add shared by the modular exponentiation block
// no dependencies
`timescale 1ns / 1ps

package mexp_pkg;

	localparam int unsigned VAL_W = 63;
	localparam int unsigned BASE_W = 64;
	localparam int unsigned CNT_W = 6;

	localparam logic [VAL_W-1:0] EXP_RESET = VAL_W'((2 << 16) + 1);
	localparam logic [VAL_W-1:0] MOD_RESET = VAL_W'(1);

	localparam logic CFG_EXPONENT = 1'b0;
	localparam logic CFG_MODULUS = 1'b1;

	typedef struct packed {
		logic signed [BASE_W-1:0] base;
	} base_t;

	typedef struct packed {
		logic [VAL_W-1:0] power;
		logic             error;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_STEP,
		ST_WAIT,
		ST_FINISH
	} state_t;

	// (x + y) mod m for x, y < m
	function automatic logic [VAL_W-1:0] add_mod(input logic [VAL_W-1:0] x,
			input logic [VAL_W-1:0] y, input logic [VAL_W-1:0] m);
		logic [VAL_W:0] s;
		logic [VAL_W:0] d;
		s = {1'b0, x} + {1'b0, y};
		d = s - {1'b0, m};
		if (s >= {1'b0, m}) begin
			return d[VAL_W-1:0];
		end
		return s[VAL_W-1:0];
	endfunction

endpackage

### sv/mexp_stream_if.sv
// valid/ready channel carrying one payload per transaction
// payload type is set by the instantiating level
`timescale 1ns / 1ps

interface mexp_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### sv/mexp_modred.sv
// bit-serial reduction of a value modulo m, msb first, one bit per cycle
// depends on mexp_pkg
`timescale 1ns / 1ps

module mexp_modred (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [mexp_pkg::VAL_W-1:0] value,
	input  logic [mexp_pkg::VAL_W-1:0] m,
	output logic                       busy,
	output logic [mexp_pkg::VAL_W-1:0] rem
);
	import mexp_pkg::*;

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [VAL_W-1:0] val_q;
	logic [VAL_W-1:0] rem_q;
	logic [VAL_W:0]   trial;
	logic [VAL_W:0]   diff;
	logic [VAL_W-1:0] rem_d;

	always_comb begin
		trial = {rem_q, val_q[VAL_W-1]};
		diff = trial - {1'b0, m};
		rem_d = (trial >= {1'b0, m}) ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CNT_W'(VAL_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= value;
			rem_q <= '0;
		end else if (busy_q) begin
			val_q <= {val_q[VAL_W-2:0], 1'b0};
			rem_q <= rem_d;
		end
	end

	assign busy = busy_q;
	assign rem = rem_q;

endmodule

### sv/mexp_mulmod.sv
// bit-serial modular multiplier, multiplier lsb first, one bit per cycle
// depends on mexp_pkg; x below 2m and y below m at start
`timescale 1ns / 1ps

module mexp_mulmod (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [mexp_pkg::VAL_W-1:0] x,
	input  logic [mexp_pkg::VAL_W-1:0] y,
	input  logic [mexp_pkg::VAL_W-1:0] m,
	output logic                       busy,
	output logic [mexp_pkg::VAL_W-1:0] prod
);
	import mexp_pkg::*;

	logic             busy_q;
	logic [VAL_W-1:0] acc_q;
	logic [VAL_W-1:0] addend_q;
	logic [VAL_W-1:0] mult_q;
	logic             mult_zero;

	assign mult_zero = (mult_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && mult_zero) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			addend_q <= (x >= m) ? x - m : x;
			mult_q <= y;
		end else if (busy_q && !mult_zero) begin
			if (mult_q[0]) begin
				acc_q <= add_mod(acc_q, addend_q, m);
			end
			addend_q <= add_mod(addend_q, addend_q, m);
			mult_q <= {1'b0, mult_q[VAL_W-1:1]};
		end
	end

	assign busy = busy_q;
	assign prod = acc_q;

endmodule

### sv/modular_exponentiation.sv
// top level: right-to-left square and multiply over two bit-serial multipliers
// depends on mexp_pkg, mexp_stream_if, mexp_modred, mexp_mulmod and the defines header
//
// channel        dir  payload                    transaction
// base_stream    in   base (64b signed)          valid && ready
// result_stream  out  power (63b), error (1b)    valid && ready
// cfg port       in   exponent, modulus          cfg_we high at a clock edge
//
// the base is reduced bit-serially first; each exponent bit up to the top set one then
// costs a pass of the serial multipliers, whose length follows the multiplier operand
// one transaction in flight
// arst_n clears control state and loads the register reset values
// a finished result waits in the output register while the next base is taken
`timescale 1ns / 1ps
`include "modular_exponentiation_defines.svh"

module modular_exponentiation (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_addr,
	input  logic [mexp_pkg::VAL_W-1:0] cfg_wdata,
	mexp_stream_if.sink                base_stream,
	mexp_stream_if.source              result_stream
);
	import mexp_pkg::*;

	state_t           state_q;
	state_t           state_d;
	logic [VAL_W-1:0] exponent_q;
	logic [VAL_W-1:0] modulus_q;
	logic [VAL_W-1:0] e_q;
	logic [VAL_W-1:0] acc_q;
	logic [VAL_W-1:0] sq_q;
	logic             err_q;
	logic             out_valid_q;
	result_t          out_q;

	logic             take_base;
	logic             reject;
	logic             red_start;
	logic             red_busy;
	logic [VAL_W-1:0] red_rem;
	logic             mul_start;
	logic             mul_busy;
	logic [VAL_W-1:0] mul_prod;
	logic             sqr_start;
	logic             sqr_busy;
	logic [VAL_W-1:0] sqr_prod;
	logic             step_done;
	logic             out_load;
	logic             out_take;

	assign reject = base_stream.data.base[BASE_W-1] || (modulus_q == '0);
	assign out_take = out_valid_q && result_stream.ready;

	always_comb begin
		state_d = state_q;
		take_base = 1'b0;
		red_start = 1'b0;
		mul_start = 1'b0;
		sqr_start = 1'b0;
		step_done = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (base_stream.valid) begin
					take_base = 1'b1;
					if (reject) begin
						state_d = ST_FINISH;
					end else begin
						red_start = 1'b1;
						state_d = ST_REDUCE;
					end
				end
			end
			ST_REDUCE: begin
				if (!red_busy) begin
					state_d = ST_STEP;
				end
			end
			ST_STEP: begin
				if (e_q == '0) begin
					state_d = ST_FINISH;
				end else begin
					mul_start = e_q[0];
					sqr_start = (e_q[VAL_W-1:1] != '0);
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (!mul_busy && !sqr_busy) begin
					step_done = 1'b1;
					state_d = ST_STEP;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || result_stream.ready) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exponent_q <= EXP_RESET;
			modulus_q <= MOD_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_EXPONENT: exponent_q <= cfg_wdata;
				CFG_MODULUS:  modulus_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_base) begin
			err_q <= reject;
			acc_q <= reject ? '0 : VAL_W'(1);
			e_q <= exponent_q;
		end
		if (state_q == ST_REDUCE && !red_busy) begin
			sq_q <= red_rem;
		end
		if (step_done) begin
			if (e_q[0]) begin
				acc_q <= mul_prod;
			end
			sq_q <= sqr_prod;
			e_q <= {1'b0, e_q[VAL_W-1:1]};
		end
		if (out_load) begin
			out_q.power <= acc_q;
			out_q.error <= err_q;
		end
	end

	// base sign is checked above, so only the low bits are reduced
	mexp_modred u_modred (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (red_start),
		.value  (base_stream.data.base[VAL_W-1:0]),
		.m      (modulus_q),
		.busy   (red_busy),
		.rem    (red_rem)
	);

	mexp_mulmod u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.x      (acc_q),
		.y      (sq_q),
		.m      (modulus_q),
		.busy   (mul_busy),
		.prod   (mul_prod)
	);

	mexp_mulmod u_sqr (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqr_start),
		.x      (sq_q),
		.y      (sq_q),
		.m      (modulus_q),
		.busy   (sqr_busy),
		.prod   (sqr_prod)
	);

	assign base_stream.ready = (state_q == ST_IDLE);
	assign result_stream.valid = out_valid_q;
	assign result_stream.data = out_q;

	`MEXP_ASSERT(a_error_zero_power,
		(result_stream.valid && result_stream.data.error) |-> (result_stream.data.power == '0),
		"error result carries nonzero power")
	`MEXP_ASSERT(a_power_in_range,
		(result_stream.valid && !result_stream.data.error) |->
		((result_stream.data.power < modulus_q) || (result_stream.data.power == VAL_W'(1))),
		"power not reduced below modulus")
	`MEXP_ASSERT(a_units_quiet_when_idle,
		(state_q == ST_IDLE) |-> (!mul_busy && !sqr_busy && !red_busy),
		"arithmetic unit busy while idle")
	`MEXP_ASSERT_NEXT(a_accept_leaves_idle,
		base_stream.valid && base_stream.ready, state_q != ST_IDLE,
		"accepted base did not start work")

endmodule

### sim/modular_exponentiation_tb.sv
`timescale 1ns / 1ps
// testbench for modular_exponentiation: directed and random bases under a series of keys
// each result is checked against an in-bench square-and-multiply predictor
// depends on mexp_pkg, mexp_stream_if and the modular_exponentiation rtl

module modular_exponentiation_tb;
	import mexp_pkg::*;

	localparam logic [VAL_W-1:0] EXPONENT_AT_RESET = 63'd131073;
	localparam logic [VAL_W-1:0] MODULUS_AT_RESET = 63'd1;
	localparam logic [VAL_W-1:0] ALL_ONES = '1;
	localparam logic [BASE_W-1:0] MOST_NEGATIVE = {1'b1, {(BASE_W-1){1'b0}}};
	localparam logic [BASE_W-1:0] MOST_POSITIVE = {1'b0, {(BASE_W-1){1'b1}}};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_addr;
	logic [VAL_W-1:0] cfg_wdata;

	mexp_stream_if #(.T(base_t)) base_if ();
	mexp_stream_if #(.T(result_t)) result_if ();

	logic rx_hold;
	int src_gap_pct;
	int snk_stall_pct;
	logic [VAL_W-1:0] key_exponent;
	logic [VAL_W-1:0] key_modulus;
	result_t powers_due[$];
	result_t want_res;
	int failures;
	int n_sent;
	int n_checked;
	int n_flagged;
	int n_cfg;

	modular_exponentiation i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.base_stream(base_if),
		.result_stream(result_if)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// exact (a * b) mod m over the full double-width product
	function automatic logic [VAL_W-1:0] mul_mod(input logic [VAL_W-1:0] a,
			input logic [VAL_W-1:0] b, input logic [VAL_W-1:0] m);
		logic [2*VAL_W-1:0] prod;
		prod = {{VAL_W{1'b0}}, a} * {{VAL_W{1'b0}}, b};
		prod = prod % {{VAL_W{1'b0}}, m};
		return prod[VAL_W-1:0];
	endfunction

	function automatic result_t predict_power(input logic [BASE_W-1:0] raw,
			input logic [VAL_W-1:0] expo, input logic [VAL_W-1:0] modv);
		result_t r;
		logic [VAL_W-1:0] acc;
		logic [VAL_W-1:0] sq;
		logic [VAL_W-1:0] e;
		r.power = '0;
		r.error = 1'b1;
		if (raw[BASE_W-1] || modv == '0) begin
			return r;
		end
		// accumulator stays at an unreduced one until first multiplied
		acc = VAL_W'(1);
		sq = raw[VAL_W-1:0] % modv;
		e = expo;
		while (e != '0) begin
			if (e[0]) begin
				acc = mul_mod(acc, sq, modv);
			end
			sq = mul_mod(sq, sq, modv);
			e = e >> 1;
		end
		r.power = acc;
		r.error = 1'b0;
		return r;
	endfunction

	function automatic logic [BASE_W-1:0] rand_base();
		logic [BASE_W-1:0] v;
		v = {$urandom, $urandom};
		if ($urandom_range(9) != 0) begin
			v[BASE_W-1] = 1'b0;
		end
		if ($urandom_range(7) == 0) begin
			v[VAL_W-1:0] = VAL_W'($urandom_range(0, 20));
		end
		return v;
	endfunction

	task automatic cfg_write(input logic idx, input logic [VAL_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_EXPONENT) begin
			key_exponent = val;
		end else begin
			key_modulus = val;
		end
		n_cfg++;
	endtask

	// valid is left high after a transaction so back-to-back items never toggle it
	task automatic send_base(input logic [BASE_W-1:0] raw);
		int gap;
		gap = 0;
		if (src_gap_pct != 0 && $urandom_range(7) == 0) begin
			gap = $urandom_range(300);
		end
		while ($urandom_range(99) < src_gap_pct) begin
			gap++;
		end
		if (gap != 0) begin
			base_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		base_if.valid <= 1'b1;
		base_if.data <= base_t'(raw);
		@(posedge clk);
		while (!base_if.ready) begin
			@(posedge clk);
		end
		powers_due.push_back(predict_power(raw, key_exponent, key_modulus));
		n_sent++;
	endtask

	task automatic settle();
		base_if.valid <= 1'b0;
		while (powers_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_if.ready <= 1'b0;
		end else begin
			result_if.ready <= !rx_hold && ($urandom_range(99) >= snk_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_if.valid && result_if.ready) begin
			if (powers_due.size() == 0) begin
				$error("unexpected result: power %0d error %0b",
					result_if.data.power, result_if.data.error);
				failures++;
			end else begin
				want_res = powers_due.pop_front();
				n_checked++;
				if (result_if.data.error) begin
					n_flagged++;
				end
				if (result_if.data.power !== want_res.power) begin
					$error("power: expected %0d, got %0d", want_res.power,
						result_if.data.power);
					failures++;
				end
				if (result_if.data.error !== want_res.error) begin
					$error("error: expected %0b, got %0b", want_res.error,
						result_if.data.error);
					failures++;
				end
			end
		end
	end

	task automatic test_reset_key();
		send_base(64'd5);
		send_base(64'd0);
		send_base(MOST_NEGATIVE);
		settle();
	endtask

	task automatic test_zero_modulus();
		cfg_write(CFG_MODULUS, '0);
		cfg_write(CFG_EXPONENT, ALL_ONES);
		send_base(64'd7);
		send_base(MOST_POSITIVE);
		send_base('1);
		settle();
	endtask

	task automatic test_zero_exponent();
		cfg_write(CFG_EXPONENT, '0);
		cfg_write(CFG_MODULUS, VAL_W'(1));
		send_base(64'd0);
		send_base(MOST_POSITIVE);
		settle();
		cfg_write(CFG_MODULUS, ALL_ONES);
		send_base(64'd12345);
		send_base(MOST_NEGATIVE);
		settle();
	endtask

	task automatic test_full_width_key();
		cfg_write(CFG_EXPONENT, ALL_ONES);
		send_base(64'd0);
		send_base(64'd1);
		send_base(64'd2);
		send_base(MOST_POSITIVE);
		send_base(MOST_POSITIVE - 64'd1);
		send_base('1);
		settle();
	endtask

	task automatic test_small_key();
		cfg_write(CFG_EXPONENT, VAL_W'(1));
		cfg_write(CFG_MODULUS, VAL_W'(2));
		send_base(64'd3);
		send_base(MOST_POSITIVE);
		settle();
		cfg_write(CFG_EXPONENT, VAL_W'(2));
		cfg_write(CFG_MODULUS, VAL_W'(10));
		send_base(64'd9);
		settle();
		cfg_write(CFG_MODULUS, ALL_ONES);
		send_base(64'h4000_0000_0000_0000);
		settle();
	endtask

	task automatic test_random_keys();
		int phase;
		int k;
		logic [VAL_W-1:0] e;
		logic [VAL_W-1:0] m;
		for (phase = 0; phase < 6; phase++) begin
			case (phase / 2)
				0: begin
					src_gap_pct = 23;
					snk_stall_pct = 56;
				end
				1: begin
					src_gap_pct = 56;
					snk_stall_pct = 23;
				end
				default: begin
					src_gap_pct = 0;
					snk_stall_pct = 0;
				end
			endcase
			e = VAL_W'({$urandom, $urandom});
			if (phase != 0) begin
				e = e >> $urandom_range(43, 62);
			end
			case ($urandom_range(3))
				0: m = VAL_W'($urandom_range(2, 1000));
				1: m = ALL_ONES - VAL_W'($urandom_range(0, 100));
				2: m = VAL_W'($urandom);
				default: m = VAL_W'({$urandom, $urandom});
			endcase
			cfg_write(CFG_EXPONENT, e);
			cfg_write(CFG_MODULUS, m);
			for (k = 0; k < 12; k++) begin
				send_base(rand_base());
			end
			settle();
		end
	endtask

	task automatic test_output_backpressure();
		int k;
		src_gap_pct = 0;
		snk_stall_pct = 0;
		cfg_write(CFG_EXPONENT, VAL_W'($urandom_range(2, 15)));
		cfg_write(CFG_MODULUS, ALL_ONES - VAL_W'($urandom_range(0, 1000)));
		fork
			begin
				rx_hold <= 1'b1;
				repeat (2000) @(posedge clk);
				rx_hold <= 1'b0;
			end
			begin
				for (k = 0; k < 8; k++) begin
					send_base(rand_base());
				end
			end
		join
		settle();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = CFG_EXPONENT;
		cfg_wdata = '0;
		base_if.valid = 1'b0;
		base_if.data = '0;
		result_if.ready = 1'b0;
		rx_hold = 1'b0;
		src_gap_pct = 23;
		snk_stall_pct = 56;
		key_exponent = EXPONENT_AT_RESET;
		key_modulus = MODULUS_AT_RESET;
		failures = 0;
		n_sent = 0;
		n_checked = 0;
		n_flagged = 0;
		n_cfg = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_key();
		test_zero_modulus();
		test_zero_exponent();
		test_full_width_key();
		test_small_key();
		test_random_keys();
		test_output_backpressure();

		repeat (4300) @(posedge clk);
		if (powers_due.size() != 0) begin
			$error("%0d results never arrived", powers_due.size());
			failures++;
		end
		$display("run covered %0d bases, %0d results checked (%0d error-flagged), %0d key writes",
			n_sent, n_checked, n_flagged, n_cfg);
		$display("keys ranged from zero and unit values to full 63-bit exponent and modulus");
		if (failures == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#40ms;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
